/* src/mm4_pkg.sv */
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
package mm4_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_DIM       = 4;
    localparam int IDX_W         = 2;
    localparam int ADDR_W        = 2 * IDX_W;
    localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
    localparam int PROD_W        = 2 * DATA_W;
    // four products summed exactly: two guard bits over one product
    localparam int ACC_W         = PROD_W + IDX_W;
    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_DIM       = 4;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] a_elem0;
        logic signed [DATA_W-1:0] a_elem1;
        logic signed [DATA_W-1:0] a_elem2;
        logic signed [DATA_W-1:0] a_elem3;
        logic signed [DATA_W-1:0] b_elem0;
        logic signed [DATA_W-1:0] b_elem1;
        logic signed [DATA_W-1:0] b_elem2;
        logic signed [DATA_W-1:0] b_elem3;
    } operands_t;

    typedef struct packed {
        logic [IDX_W-1:0]         row_index;
        logic signed [DATA_W-1:0] c_elem0;
        logic signed [DATA_W-1:0] c_elem1;
        logic signed [DATA_W-1:0] c_elem2;
        logic signed [DATA_W-1:0] c_elem3;
        logic                     clipped;
        logic                     last;
    } result_t;

    // one multiply issue: position of the product within the matrix
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_k;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tag_t;

    // one finished dot product, before scaling
    typedef struct packed {
        logic                    valid;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [ACC_W-1:0] sum;
    } elem_t;

endpackage

/* src/mm4_store.sv */
// Row storage for matrices A and B with registered single-address reads.
module mm4_store
    import mm4_pkg::*;
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [IDX_W-1:0]         wrow,
    input  operands_t                operands,
    input  logic [ADDR_W-1:0]        a_addr,
    input  logic [ADDR_W-1:0]        b_addr,
    output logic signed [DATA_W-1:0] a_rd,
    output logic signed [DATA_W-1:0] b_rd
);

    logic [DATA_W-1:0] a_mem [STORE_DEPTH];
    logic [DATA_W-1:0] b_mem [STORE_DEPTH];
    logic [DATA_W-1:0] a_row [MAX_DIM];
    logic [DATA_W-1:0] b_row [MAX_DIM];
    logic [DATA_W-1:0] a_rd_reg;
    logic [DATA_W-1:0] b_rd_reg;

    always_comb
    begin
        a_row[0] = operands.a_elem0;
        a_row[1] = operands.a_elem1;
        a_row[2] = operands.a_elem2;
        a_row[3] = operands.a_elem3;
        b_row[0] = operands.b_elem0;
        b_row[1] = operands.b_elem1;
        b_row[2] = operands.b_elem2;
        b_row[3] = operands.b_elem3;
    end

    // whole row written at once; unused columns are never read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int i = 0; i < MAX_DIM; i++)
            begin
                a_mem[{wrow, IDX_W'(i)}] <= a_row[i];
                b_mem[{wrow, IDX_W'(i)}] <= b_row[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_rd_reg <= a_mem[a_addr];
        b_rd_reg <= b_mem[b_addr];
    end

    assign a_rd = $signed(a_rd_reg);
    assign b_rd = $signed(b_rd_reg);

endmodule

/* src/mm4_mac.sv */
// Shared 32x32 signed multiplier followed by a wide accumulator.
module mm4_mac
    import mm4_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [DATA_W-1:0] a_val,
    input  logic signed [DATA_W-1:0] b_val,
    input  tag_t                     tag,
    output elem_t                    elem
);

    logic signed [PROD_W-1:0] prod_reg;
    tag_t                     tag_p_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     elem_valid_reg;
    logic [IDX_W-1:0]         row_reg;
    logic [IDX_W-1:0]         col_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a_val) * PROD_W'(b_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_p_reg      <= '0;
            elem_valid_reg <= 1'b0;
        end
        else
        begin
            tag_p_reg      <= tag;
            elem_valid_reg <= tag_p_reg.valid && tag_p_reg.last_k;
        end
    end

    always_comb
    begin
        if (tag_p_reg.first)
            acc_next = ACC_W'(prod_reg);
        else
            acc_next = acc_reg + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (tag_p_reg.valid)
        begin
            acc_reg <= acc_next;
            row_reg <= tag_p_reg.row;
            col_reg <= tag_p_reg.col;
        end
    end

    assign elem.valid = elem_valid_reg;
    assign elem.row   = row_reg;
    assign elem.col   = col_reg;
    assign elem.sum   = acc_reg;

endmodule

/* src/mm4_out.sv */
// Scaling, saturation and row assembly of finished product elements.
module mm4_out
    import mm4_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int DIM       = DEF_DIM
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  elem_t   elem,
    output logic    done,
    output result_t result
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

    logic signed [ACC_W-1:0] shifted;
    logic                    fits;
    logic                    sat;
    logic [DATA_W-1:0]       val;
    logic [DATA_W-1:0]       c_buf_reg [MAX_DIM];
    logic                    clip_reg;
    logic [DATA_W-1:0]       row_vals [MAX_DIM];
    logic                    row_clip;
    result_t                 result_reg;
    result_t                 result_next;
    logic                    done_reg;

    assign shifted = $signed(elem.sum) >>> FRAC_BITS;
    assign fits    = (&shifted[ACC_W-1:DATA_W-1]) || !(|shifted[ACC_W-1:DATA_W-1]);
    assign sat     = !fits;

    always_comb
    begin
        if (fits)
            val = shifted[DATA_W-1:0];
        else if (shifted[ACC_W-1])
            val = SAT_MIN;
        else
            val = SAT_MAX;
    end

    always_comb
    begin
        for (int i = 0; i < MAX_DIM; i++)
        begin
            if (i >= DIM)
                row_vals[i] = '0;
            else if (IDX_W'(i) == elem.col)
                row_vals[i] = val;
            else
                row_vals[i] = c_buf_reg[i];
        end
        row_clip = ((elem.col == '0) ? 1'b0 : clip_reg) | sat;

        result_next.row_index = elem.row;
        result_next.c_elem0   = row_vals[0];
        result_next.c_elem1   = row_vals[1];
        result_next.c_elem2   = row_vals[2];
        result_next.c_elem3   = row_vals[3];
        result_next.clipped   = row_clip;
        result_next.last      = (elem.row == LAST_IDX);
    end

    always_ff @(posedge clk)
    begin
        if (elem.valid)
        begin
            c_buf_reg[elem.col] <= val;
            clip_reg            <= row_clip;
            if (elem.col == LAST_IDX)
                result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= elem.valid && (elem.col == LAST_IDX);
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* src/matrix4x4_multiply.sv */
// Top level: row loading, product sequencer and the shared multiply path.
//
// Each item on operands carries one row of A and the same row of B, rows
// 0..DIM-1 in order; a row that does not complete the matrix is stored
// and busy stays low. The item that completes the matrix raises busy: one
// shared 32x32 multiplier forms one product per cycle, and the DIM*DIM*DIM
// products pass through a read, multiply, accumulate and saturate
// pipeline. The DIM result rows come out in order, one done strobe each,
// the last one marked; busy drops the cycle after the last row. The done
// strobe is high for a single cycle; result holds until the next row
// replaces it, and neither can be stalled.
module matrix4x4_multiply
    import mm4_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int DIM       = DEF_DIM
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  operands_t operands,
    output logic      done,
    output result_t   result
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         rows_loaded_reg, rows_loaded_next;
    logic [IDX_W-1:0]         r_reg, r_next;
    logic [IDX_W-1:0]         c_reg, c_next;
    logic [IDX_W-1:0]         k_reg, k_next;
    logic                     accept;
    tag_t                     issue_tag;
    tag_t                     tag_rd_reg;
    logic signed [DATA_W-1:0] a_rd;
    logic signed [DATA_W-1:0] b_rd;
    elem_t                    elem;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign issue_tag.valid  = (state_reg == ST_ISSUE);
    assign issue_tag.first  = (k_reg == '0);
    assign issue_tag.last_k = (k_reg == LAST_IDX);
    assign issue_tag.row    = r_reg;
    assign issue_tag.col    = c_reg;

    always_comb
    begin
        state_next       = state_reg;
        rows_loaded_next = rows_loaded_reg;
        r_next           = r_reg;
        c_next           = c_reg;
        k_next           = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (rows_loaded_reg == LAST_IDX)
                    begin
                        rows_loaded_next = '0;
                        r_next           = '0;
                        c_next           = '0;
                        k_next           = '0;
                        state_next       = ST_ISSUE;
                    end
                    else
                    begin
                        rows_loaded_next = rows_loaded_reg + 1'b1;
                    end
                end
            end
            ST_ISSUE:
            begin
                // k innermost, then column, then row
                if (k_reg == LAST_IDX)
                begin
                    k_next = '0;
                    if (c_reg == LAST_IDX)
                    begin
                        c_next = '0;
                        if (r_reg == LAST_IDX)
                        begin
                            r_next     = '0;
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            r_next = r_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (done && result.last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rows_loaded_reg <= '0;
            r_reg           <= '0;
            c_reg           <= '0;
            k_reg           <= '0;
            tag_rd_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            rows_loaded_reg <= rows_loaded_next;
            r_reg           <= r_next;
            c_reg           <= c_next;
            k_reg           <= k_next;
            tag_rd_reg      <= issue_tag;
        end
    end

    mm4_store u_store (
        .clk      (clk),
        .we       (accept),
        .wrow     (rows_loaded_reg),
        .operands (operands),
        .a_addr   ({r_reg, k_reg}),
        .b_addr   ({k_reg, c_reg}),
        .a_rd     (a_rd),
        .b_rd     (b_rd)
    );

    mm4_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .a_val (a_rd),
        .b_val (b_rd),
        .tag   (tag_rd_reg),
        .elem  (elem)
    );

    mm4_out #(
        .FRAC_BITS (FRAC_BITS),
        .DIM       (DIM)
    ) u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .elem   (elem),
        .done   (done),
        .result (result)
    );

    // results only appear while a product is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done && result.last))
        else $error("busy dropped before the final row");

    a_rows_clear: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (rows_loaded_reg == '0))
        else $error("row count not cleared during product");

    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.last) |-> (result.row_index == LAST_IDX))
        else $error("last flag on wrong row");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the 4x4 fixed-point matrix multiplier.
module testbench;
    import mm4_pkg::*;

    localparam int                 Q_FRAC = DEF_FRAC_BITS;
    localparam logic signed [65:0] SUM_HI = 66'sd2147483647;
    localparam logic signed [65:0] SUM_LO = -66'sd2147483648;
    localparam logic [31:0]        ONE_Q  = 32'h0001_0000;

    typedef struct {
        operands_t ops;
        bit        drain;  // hold this item back until all product rows are out
    } row_pair_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    operands_t operands = '0;
    logic      busy;
    logic      done;
    result_t   result;

    row_pair_t row_pairs[$];
    result_t   product_rows_due[$];
    row_pair_t next_pair;
    result_t   want;

    logic signed [31:0] mat_a [4][4];
    logic signed [31:0] mat_b [4][4];
    logic [1:0]         rows_in = '0;

    int items_total = 0;
    int items_sent = 0;
    int gap_left = 0;
    int errors = 0;

    matrix4x4_multiply dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operands (operands),
        .done     (done),
        .result   (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // exact sum of four products, floor shift, then clamp to 32 bits
    function automatic logic [31:0] dot_sat(input int r, input int c, inout bit sat);
        logic signed [65:0] acc;
        logic signed [65:0] wa;
        logic signed [65:0] wb;
        acc = '0;
        for (int k = 0; k < 4; k++)
        begin
            wa = 66'(mat_a[r][k]);
            wb = 66'(mat_b[k][c]);
            acc = acc + wa * wb;
        end
        acc = acc >>> Q_FRAC;
        if (acc > SUM_HI)
        begin
            sat = 1'b1;
            return SAT_MAX;
        end
        if (acc < SUM_LO)
        begin
            sat = 1'b1;
            return SAT_MIN;
        end
        return acc[31:0];
    endfunction

    task automatic take_row(input operands_t op);
        logic [31:0] e [4];
        bit          sat;
        result_t     rr;
        mat_a[rows_in] = '{op.a_elem0, op.a_elem1, op.a_elem2, op.a_elem3};
        mat_b[rows_in] = '{op.b_elem0, op.b_elem1, op.b_elem2, op.b_elem3};
        if (rows_in == 2'd3)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sat = 1'b0;
                for (int c = 0; c < 4; c++)
                    e[c] = dot_sat(r, c, sat);
                rr.row_index = r[1:0];
                rr.c_elem0   = e[0];
                rr.c_elem1   = e[1];
                rr.c_elem2   = e[2];
                rr.c_elem3   = e[3];
                rr.clipped   = sat;
                rr.last      = (r == 3);
                product_rows_due.push_back(rr);
            end
        end
        rows_in = rows_in + 2'd1;
    endtask

    task automatic push_row(input logic [31:0] a0, a1, a2, a3, b0, b1, b2, b3,
                            input bit drain);
        row_pair_t p;
        p.ops   = '{a0, a1, a2, a3, b0, b1, b2, b3};
        p.drain = drain;
        row_pairs.push_back(p);
    endtask

    // mostly small Q16.16 values, with full-range words and corner values mixed in
    function automatic logic [31:0] rand_elem();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0, 1:       v = v;
            2, 3, 4, 5: v = $signed(v) >>> $urandom_range(8, 28);
            6, 7:       v = $signed(v) >>> $urandom_range(1, 7);
            default:
                case ($urandom_range(0, 6))
                    0: v = 32'h0;
                    1: v = 32'h1;
                    2: v = 32'hFFFF_FFFF;
                    3: v = SAT_MAX;
                    4: v = SAT_MIN;
                    5: v = ONE_Q;
                    default: v = -ONE_Q;
                endcase
        endcase
        return v;
    endfunction

    // driver: one item per start, held until the block takes it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                take_row(operands);
                items_sent++;
                if (row_pairs.size() > 40 && $urandom_range(0, 2) == 0)
                    gap_left = $urandom_range(1, 19);
            end
            if (start && busy)
                ;
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (row_pairs.size() > 0 &&
                     !(row_pairs[0].drain && product_rows_due.size() != 0))
            begin
                next_pair = row_pairs.pop_front();
                operands <= next_pair.ops;
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, got_v);
            errors++;
        end
    endtask

    // monitor: every strobed row is matched against the oldest predicted row
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (product_rows_due.size() == 0)
            begin
                $error("unexpected result row %0d", result.row_index);
                errors++;
            end
            else
            begin
                want = product_rows_due.pop_front();
                check_field("row_index", 32'(want.row_index), 32'(result.row_index));
                check_field("c_elem0", want.c_elem0, result.c_elem0);
                check_field("c_elem1", want.c_elem1, result.c_elem1);
                check_field("c_elem2", want.c_elem2, result.c_elem2);
                check_field("c_elem3", want.c_elem3, result.c_elem3);
                check_field("clipped", 32'(want.clipped), 32'(result.clipped));
                check_field("last", 32'(want.last), 32'(result.last));
            end
        end
    end

    initial
    begin
        // identity times a random B
        for (int r = 0; r < 4; r++)
            push_row(r == 0 ? ONE_Q : 32'h0, r == 1 ? ONE_Q : 32'h0,
                     r == 2 ? ONE_Q : 32'h0, r == 3 ? ONE_Q : 32'h0,
                     $urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
        // all max: positive clamp
        for (int r = 0; r < 4; r++)
            push_row(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                     SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 1'b0);
        // all min: largest possible positive sum
        for (int r = 0; r < 4; r++)
            push_row(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN,
                     SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 1'b0);
        // min times max: negative clamp
        for (int r = 0; r < 4; r++)
            push_row(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN,
                     SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 1'b0);
        // exact bounds, rounding of small negatives toward minus infinity, zero row
        push_row(SAT_MAX, 32'h0, 32'h0, 32'h0,
                 ONE_Q, ONE_Q + 32'h1, -ONE_Q, 32'h1, 1'b0);
        push_row(SAT_MIN, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        push_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'h1, 32'h1, 32'h1, 32'h1, 1'b0);
        push_row(32'h0, 32'h0, 32'h0, 32'h0, SAT_MAX, SAT_MIN, 32'hFFFF_FFFF, 32'h0, 1'b0);

        for (int m = 0; m < 90; m++)
            for (int r = 0; r < 4; r++)
                push_row(rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                         rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                         r == 0 && m % 16 == 0);
        items_total = row_pairs.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (items_sent != items_total)
            @(posedge clk);
        while (product_rows_due.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
src/mm4_pkg.sv
src/mm4_store.sv
src/mm4_mac.sv
src/mm4_out.sv
src/matrix4x4_multiply.sv
sim/testbench.sv
